// ----- hdl/olir_pkg.sv -----
package olir_pkg;

	localparam int OLIR_CAPACITY   = 64;
	localparam int OLIR_DATA_WIDTH = 32;

	// Fixed widths of the request and result fields.
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 7;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_MISS     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		PH_IDLE = 1'b0,
		PH_EXEC = 1'b1
	} phase_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic sample;   // take a match snapshot against the probe value
		logic insert;   // committed insert at the given position
		logic remove;   // committed remove at the first match
	} cell_ctrl_t;

endpackage

// ----- hdl/olir_cell.sv -----
module olir_cell
	import olir_pkg::*;
#(
	parameter int DATA_WIDTH = OLIR_DATA_WIDTH,
	parameter int CMPW       = POS_W,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [DATA_WIDTH-1:0] probe,
	input  logic [DATA_WIDTH-1:0] load_word,
	input  logic [CMPW-1:0]       pos,
	input  logic [CMPW-1:0]       count,
	input  logic                  remove_here,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match
);

	localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  match_q;

	// The entry holds data only while its index is below the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.sample) begin
			match_q <= (IDX < count) && (data_q == probe);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (IDX == pos) begin
				data_q <= load_word;
			end else if (IDX > pos) begin
				data_q <= left_data;
			end
		end else if (ctrl.remove && remove_here) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ----- hdl/ordered_list_insert_remove.sv -----
// Ordered list of signed values with insert-at-position and remove-by-value.
//
// Request channel (in_valid/in_ready) carries req_type, value and position.
// Result channel (out_valid/out_ready) returns one transaction per request:
// status and the list length after the request.
//
// Each entry sits in its own cell of a chain. A request is taken in two
// steps: at acceptance every cell compares its entry against the value, and
// in the shift step the cells from the insert position or first match on
// shift toward or away from their neighbors in parallel. The first match of a
// remove is found with a single wide subtract over the registered match bits.
//
// A new request is accepted only once the previous one has left the shift
// step, so one request is in the cell chain at a time. A new request is
// accepted while an earlier result still waits; if the receiver stalls,
// the second request holds in the shift step until the result register
// frees up.
// Reset clears the entry count and the handshake state. The entries are not
// cleared; only entries below the count are ever read.
module ordered_list_insert_remove
	import olir_pkg::*;
#(
	parameter int CAPACITY   = OLIR_CAPACITY,
	parameter int DATA_WIDTH = OLIR_DATA_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]           position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [LEN_W-1:0]           length
);

	// Count width holds the value CAPACITY itself; comparisons use a width
	// that fits both the count and the position field.
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	phase_t phase_q, phase_n;

	logic                  req_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CMPW-1:0]       pos_q;
	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [LEN_W-1:0]      length_q;

	logic                  accept;
	logic                  exec_fire;
	logic [DATA_WIDTH-1:0] probe;
	logic [CMPW-1:0]       count_x;
	logic                  full;
	logic                  ins_ok;
	logic                  any_hit;
	logic [CAPACITY-1:0]   hit_vec_r;
	logic [CAPACITY-1:0]   below_hit;
	logic [CAPACITY-1:0]   from_hit;
	cell_ctrl_t            ctrl;
	status_t               status_n;
	logic [CW-1:0]         count_n;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	// Values are kept on their low DATA_WIDTH bits; a narrower value is
	// zero-extended.
	assign probe   = DATA_WIDTH'($unsigned(value));
	assign count_x = CMPW'(count_q);

	assign accept    = in_valid && in_ready;
	assign exec_fire = (phase_q == PH_EXEC) && (!out_valid_q || out_ready);

	// Next-state logic.
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (in_valid) begin
					phase_n = PH_EXEC;
				end
			end
			PH_EXEC: begin
				if (exec_fire) begin
					phase_n = PH_IDLE;
				end
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		unique case (phase_q)
			PH_IDLE: in_ready = 1'b1;
			PH_EXEC: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			word_q <= probe;
			pos_q  <= CMPW'(position);
		end
	end

	// The lowest set match bit is the first equal entry from the front.
	// Every cell at or above it takes its right neighbor's entry.
	assign any_hit   = |hit_vec_r;
	assign below_hit = (hit_vec_r - CAPACITY'(1)) & ~hit_vec_r;
	assign from_hit  = ~below_hit;

	// The full check comes before the position check.
	assign full   = (count_x == CMPW'(CAPACITY));
	assign ins_ok = !full && !(pos_q > count_x);

	always_comb begin
		ctrl.sample = accept;
		ctrl.insert = exec_fire && (req_q == REQ_INSERT) && ins_ok;
		ctrl.remove = exec_fire && (req_q == REQ_REMOVE) && any_hit;
	end

	always_comb begin
		count_n = count_q;
		if (req_q == REQ_INSERT) begin
			priority if (full) begin
				status_n = ST_FULL;
			end else if (!ins_ok) begin
				status_n = ST_MISS;
			end else begin
				status_n = ST_INSERTED;
				count_n  = count_q + CW'(1);
			end
		end else begin
			if (any_hit) begin
				status_n = ST_REMOVED;
				count_n  = count_q - CW'(1);
			end else begin
				status_n = ST_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				count_q     <= count_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q <= status_n;
			length_q <= LEN_W'(count_n);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		// The front cell never shifts right and the back cell never shifts
		// left past the count, so their outer neighbors are their own entry.
		if (g == 0) begin : g_front
			assign left_d = cell_data[g];
		end else begin : g_inner_l
			assign left_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_back
			assign right_d = cell_data[g];
		end else begin : g_inner_r
			assign right_d = cell_data[g+1];
		end

		olir_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CMPW       (CMPW),
			.INDEX      (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.probe       (probe),
			.load_word   (word_q),
			.pos         (pos_q),
			.count       (count_x),
			.remove_here (from_hit[g]),
			.left_data   (left_d),
			.right_data  (right_d),
			.data        (cell_data[g]),
			.match       (hit_vec_r[g])
		);
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign length    = length_q;

endmodule

// ----- hdl/olir_checker.sv -----
module olir_checker
	import olir_pkg::*;
#(
	parameter int CAPACITY = OLIR_CAPACITY
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [LEN_W-1:0]    length
);

	// A held result keeps its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(length))
		else $error("result changed while stalled");

	// One request is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in the shift step");

	// A full status comes with a length equal to the capacity.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (length == LEN_W'(CAPACITY)))
		else $error("full status with a length other than capacity");

	// The count never passes capacity, and an insert leaves a nonempty list.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY > 127) ||
			((length <= LEN_W'(CAPACITY)) && ((status != ST_INSERTED) || (length != '0))))
		else $error("length out of range");

endmodule

bind ordered_list_insert_remove olir_checker #(
	.CAPACITY (CAPACITY)
) u_olir_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.length    (length)
);

// ----- tb/olir_list_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the list, keeps a shadow copy of its contents and
// compares every result transaction against the outcome the shadow predicts.
module olir_list_checker
	import olir_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      req_type,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [STATUS_W-1:0]       status,
	input  logic [LEN_W-1:0]          length,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		status_t          st;
		logic [LEN_W-1:0] len;
	} outcome_t;

	logic [OLIR_DATA_WIDTH-1:0] shadow_entries [OLIR_CAPACITY];
	int                         shadow_count;
	outcome_t                   outcome_q [$];
	outcome_t                   head;

	// Applies one request to the shadow list and returns its status and length.
	function automatic outcome_t apply_list_request(req_t kind,
			logic [OLIR_DATA_WIDTH-1:0] word, int pos);
		outcome_t res;
		int       hit;
		res.st = ST_MISS;
		if (kind == REQ_INSERT) begin
			if (shadow_count >= OLIR_CAPACITY) begin
				res.st = ST_FULL;
			end else if (pos <= shadow_count) begin
				for (int i = shadow_count; i > pos; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[pos] = word;
				shadow_count++;
				res.st = ST_INSERTED;
			end
		end else begin
			hit = -1;
			for (int i = 0; i < shadow_count; i++) begin
				if (hit < 0 && shadow_entries[i] == word)
					hit = i;
			end
			if (hit >= 0) begin
				for (int i = hit; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				res.st = ST_REMOVED;
			end
		end
		res.len = LEN_W'(shadow_count);
		return res;
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			outcome_q.delete();
		end else begin
			if (in_valid && in_ready)
				outcome_q = {outcome_q, apply_list_request(req_t'(req_type),
					value[OLIR_DATA_WIDTH-1:0], int'(position))};
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("unrequested result transaction: status %0d length %0d",
						status, length);
					errors++;
				end else begin
					head = outcome_q.pop_front();
					if (status !== head.st) begin
						$error("status: expected %0d, actual %0d", head.st, status);
						errors++;
					end
					if (length !== head.len) begin
						$error("length: expected %0d, actual %0d", head.len, length);
						errors++;
					end
				end
			end
		end
		pending = outcome_q.size();
	end

endmodule

// ----- tb/ordered_list_insert_remove_tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the ordered list. The checker beside the block does
// all of the prediction and comparison; this module only drives requests,
// throttles the result channel and decides when the run is over.
module ordered_list_insert_remove_tb;
	import olir_pkg::*;

	// Worst case per request is roughly a long sender gap plus a long receiver
	// stall plus the compare and shift steps of the block itself, so this
	// limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASE_LEN    = 130;
	localparam int RING_DEPTH   = 32;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      req_type;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic [LEN_W-1:0]          length;

	int   errors;
	int   pending;
	int   cycle_count;

	// When set, neither side idles, so the block runs at its full rate.
	logic calm;

	// A small set of values that repeat often, so that removes find matches and
	// duplicates sit in the list. The extremes of the signed range are included.
	logic [VALUE_W-1:0] value_pool [8] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'h1234_5678, 32'h0000_FFFF, 32'hA5A5_5A5A
	};

	// The most recently inserted values; removes draw from here so that they
	// often hit entries that are really held.
	logic [VALUE_W-1:0] recent_inserts [RING_DEPTH];
	int                 ring_wr;

	ordered_list_insert_remove uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.length    (length)
	);

	olir_list_checker list_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.length    (length),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("ordered_list_insert_remove_tb: done, errors");
				$finish;
			end
		end
	end

	// Idle length: none when calm, else mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side throttling. Each assignment lands on its own falling edge, so
	// out_ready never gets two updates in one time step.
	initial begin
		int low_len;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			low_len = pick_gap();
			if (low_len > 0) begin
				out_ready <= 1'b0;
				repeat (low_len) @(negedge clk);
			end
			out_ready <= 1'b1;
			if (!calm)
				repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	end

	// Presents one request after an idle gap and holds it until the block takes
	// the transaction. On return we sit just past the accepting rising edge.
	task automatic send_request(req_t kind, logic [VALUE_W-1:0] word,
			logic [POS_W-1:0] pos, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		value    <= word;
		position <= pos;
		if (kind == REQ_INSERT) begin
			recent_inserts[ring_wr] = word;
			ring_wr = (ring_wr + 1) % RING_DEPTH;
		end
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value(bit for_remove);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return value_pool[$urandom_range(0, 7)];
		if (r < (for_remove ? 85 : 70))
			return recent_inserts[$urandom_range(0, RING_DEPTH - 1)];
		return $urandom();
	endfunction

	// Positions are mostly near the front or within the capacity, so most of
	// the inserts are legal, with some beyond any possible length.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return POS_W'($urandom_range(0, 2));
		if (r < 85)
			return POS_W'($urandom_range(0, OLIR_CAPACITY));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	initial begin
		int   phase;
		int   insert_pct;
		req_t kind;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		value    = '0;
		position = '0;
		calm     = 1'b0;
		ring_wr  = 0;
		for (int i = 0; i < RING_DEPTH; i++)
			recent_inserts[i] = value_pool[i % 8];

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Removing from an empty list, inserts past the length,
		// front, middle and end inserts, the signed extremes, duplicates where
		// only the first match goes, and a remove that finds nothing.
		send_request(REQ_REMOVE, 32'h0000_0005, 7'd0,   0);
		send_request(REQ_INSERT, 32'h0000_0009, 7'd3,   0);
		send_request(REQ_INSERT, 32'h7FFF_FFFF, 7'd0,   0);
		send_request(REQ_INSERT, 32'h8000_0000, 7'd1,   1);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 7'd0,   0);
		send_request(REQ_INSERT, 32'h0000_0000, 7'd2,   0);
		send_request(REQ_INSERT, 32'h7FFF_FFFF, 7'd4,   2);
		send_request(REQ_INSERT, 32'h0000_0007, 7'd127, 0);
		send_request(REQ_INSERT, 32'h0000_0009, 7'd6,   0);
		send_request(REQ_REMOVE, 32'h7FFF_FFFF, 7'd0,   0);
		send_request(REQ_REMOVE, 32'h7FFF_FFFF, 7'd127, 0);
		send_request(REQ_REMOVE, 32'h7FFF_FFFF, 7'd0,   3);
		send_request(REQ_REMOVE, 32'h8000_0000, 7'd0,   0);
		send_request(REQ_INSERT, 32'h5555_5555, 7'd64,  0);
		send_request(REQ_INSERT, 32'hAAAA_AAAA, 7'd1,   0);
		send_request(REQ_INSERT, 32'h5555_5555, 7'd3,   0);
		send_request(REQ_REMOVE, 32'hFFFF_FFFF, 7'd0,   0);
		send_request(REQ_REMOVE, 32'h0000_0000, 7'd0,   0);
		send_request(REQ_REMOVE, 32'hAAAA_AAAA, 7'd0,   0);
		send_request(REQ_REMOVE, 32'h5555_5555, 7'd0,   0);
		send_request(REQ_REMOVE, 32'h0000_0000, 7'd0,   0);

		// Random part, in phases. Growing phases push the list to full and keep
		// hitting it, shrinking phases drain it toward empty, and mixed phases
		// churn in between. Every fourth phase runs with no idling at all.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			phase = (k / PHASE_LEN) % 3;
			calm  = ((k / PHASE_LEN) % 4) == 3;
			case (phase)
				0: insert_pct = 85;
				1: insert_pct = 15;
				default: insert_pct = 50;
			endcase
			kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
			send_request(kind, pick_value(kind == REQ_REMOVE), pick_position(),
				pick_gap());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		calm = 1'b0;

		// Drain the outstanding results, then let the block run on so that any
		// stray result transaction is caught by the checker.
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("ordered_list_insert_remove_tb: done, clean");
		else
			$display("ordered_list_insert_remove_tb: done, errors");
		$finish;
	end

endmodule
